// ----- rtl/bsda_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bsda_pkg;

   localparam int CSR_BITS   = 9;
   localparam int IDX_BITS   = 8;
   localparam int IN_BITS    = 32;
   localparam int OUT_BITS   = 32;
   localparam int FILL_OUT   = 9;

   typedef enum logic [2:0] {
      OP_PUSH       = 3'd0,
      OP_POP        = 3'd1,
      OP_READ_TOP   = 3'd2,
      OP_READ_DEEP  = 3'd3,
      OP_WRITE_DEEP = 3'd4,
      OP_CLEAR      = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic execute;
      logic finish;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
   } dp_stat_type;

endpackage

`default_nettype wire

// ----- rtl/bsda_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bsda_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output bsda_pkg::dp_cmd_type  cmd,
   input  bsda_pkg::dp_stat_type stat
);
   import bsda_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_LOAD = 3'b100
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      cmd.finish  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = S_LOAD;
         end
         S_LOAD: begin
            // wait here until the output register can take the result
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef ASSERT_OFF
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.execute, cmd.finish}))
      else $error("more than one datapath command at once");
   a_exec_follows_capture: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> cmd.execute)
      else $error("capture not followed by execute");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.execute || cmd.finish) |-> !req_ready)
      else $error("request taken while an item is in flight");
`endif

endmodule

`default_nettype wire

// ----- rtl/bsda_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bsda_dp #(
   parameter int DEPTH     = 256,
   parameter int WORD_BITS = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  bsda_pkg::dp_cmd_type                    cmd,
   output bsda_pkg::dp_stat_type                   stat,
   input  logic                                    csr_wr_en,
   input  logic [bsda_pkg::CSR_BITS-1:0]           csr_wr_data,
   input  logic [2:0]                              req_operation,
   input  logic signed [bsda_pkg::IN_BITS-1:0]     req_value,
   input  logic [bsda_pkg::IDX_BITS-1:0]           req_depth_index,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [bsda_pkg::OUT_BITS-1:0]    rsp_data,
   output logic [1:0]                              rsp_status,
   output logic [bsda_pkg::FILL_OUT-1:0]           rsp_fill_count,
   output logic                                    rsp_is_empty,
   output logic                                    rsp_is_full
);
   import bsda_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FW = $clog2(DEPTH + 1);
   localparam int CW = (FW > CSR_BITS) ? FW : CSR_BITS;

   logic [WORD_BITS-1:0] mem [DEPTH];
   logic [WORD_BITS-1:0] rdata_ff;

   logic [2:0]            op_ff;
   logic [WORD_BITS-1:0]  val_ff;
   logic [IDX_BITS-1:0]   idx_ff;
   logic [CW-1:0]         capacity_ff;
   logic [FW-1:0]         fill_ff, fill_in;
   logic [1:0]            status_ff, status_in;
   logic                  fail_ff, fail_in;
   logic                  rd_ok_ff, rd_ok_in;

   logic                  rsp_valid_ff;
   logic [OUT_BITS-1:0]   data_ff;
   logic [1:0]            rsp_status_ff;
   logic [FILL_OUT-1:0]   fill_out_ff;
   logic                  empty_ff, full_ff;

   logic [CW-1:0]         cap_eff, fill_cw, idx_cw, deep_pos;
   logic                  mem_we;
   logic [AW-1:0]         waddr, raddr;
   logic [WORD_BITS-1:0]  wdata;
   logic signed [63:0]    rd_wide;
   logic [OUT_BITS-1:0]   data_in;

   // effective capacity saturates at the stored depth
   assign cap_eff  = (capacity_ff > CW'(DEPTH)) ? CW'(DEPTH) : capacity_ff;
   assign fill_cw  = CW'(fill_ff);
   assign idx_cw   = CW'(idx_ff);
   assign deep_pos = fill_cw - CW'(1) - idx_cw;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CW'(DEPTH);
      end else if (csr_wr_en) begin
         capacity_ff <= CW'(csr_wr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_operation;
         val_ff <= WORD_BITS'(64'(req_value));
         idx_ff <= req_depth_index;
      end
   end

   always_comb begin
      fill_in   = fill_ff;
      status_in = ST_OK;
      fail_in   = 1'b0;
      rd_ok_in  = 1'b0;
      mem_we    = 1'b0;
      waddr     = fill_ff[AW-1:0];
      raddr     = deep_pos[AW-1:0];
      wdata     = val_ff;
      unique case (op_ff) inside
         OP_PUSH: begin
            if (fill_cw >= cap_eff) begin
               status_in = ST_FULL;
               fail_in   = 1'b1;
            end else begin
               mem_we  = 1'b1;
               fill_in = fill_ff + FW'(1);
            end
         end
         OP_POP, OP_READ_TOP: begin
            raddr = AW'(fill_ff - FW'(1));
            if (fill_ff == '0) begin
               status_in = ST_EMPTY;
               fail_in   = 1'b1;
            end else begin
               rd_ok_in = 1'b1;
               if (op_ff == OP_POP) begin
                  fill_in = fill_ff - FW'(1);
               end
            end
         end
         OP_READ_DEEP, OP_WRITE_DEEP: begin
            waddr = deep_pos[AW-1:0];
            if (fill_ff == '0) begin
               status_in = ST_EMPTY;
               fail_in   = 1'b1;
            end else if (idx_cw >= fill_cw) begin
               status_in = ST_RANGE;
               fail_in   = 1'b1;
            end else if (op_ff == OP_READ_DEEP) begin
               rd_ok_in = 1'b1;
            end else begin
               mem_we = 1'b1;
            end
         end
         OP_CLEAR: fill_in = '0;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.execute && mem_we) begin
         mem[waddr] <= wdata;
      end
      if (cmd.execute) begin
         rdata_ff <= mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         status_ff <= status_in;
         fail_ff   <= fail_in;
         rd_ok_ff  <= rd_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (cmd.execute) begin
         fill_ff <= fill_in;
      end
   end

   assign rd_wide = 64'(signed'(rdata_ff));
   assign data_in = rd_ok_ff ? rd_wide[OUT_BITS-1:0] :
                    (fail_ff ? '1 : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         data_ff       <= data_in;
         rsp_status_ff <= status_ff;
         fill_out_ff   <= FILL_OUT'(fill_cw);
         empty_ff      <= (fill_ff == '0);
         full_ff       <= (fill_cw >= cap_eff);
      end
   end

   assign stat.out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data       = data_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_fill_count = fill_out_ff;
   assign rsp_is_empty   = empty_ff;
   assign rsp_is_full    = full_ff;

`ifndef ASSERT_OFF
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_cw <= CW'(DEPTH))
      else $error("fill beyond stored depth");
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> stat.out_free)
      else $error("result loaded over a pending transfer");
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.execute && op_ff == OP_PUSH && fill_cw < cap_eff)
      |=> fill_ff == $past(fill_ff) + FW'(1))
      else $error("push did not advance fill");
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (cmd.execute && op_ff == OP_CLEAR) |=> fill_ff == '0)
      else $error("clear left entries");
`endif

endmodule

`default_nettype wire

// ----- rtl/bounded_stack_with_deep_access.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake             payload
// req_      in         req_valid/req_ready   operation, value, depth_index
// rsp_      out        rsp_valid/rsp_ready   data, status, fill_count, is_empty, is_full
// csr_      in         csr_wr_en             wr_data (capacity)
//
// each request passes through capture, stack memory access and result load;
// the read of the stack memory is registered, so the access has a step of its own
// a new request is taken while an earlier result still waits in the output register
// a stalled output holds the item in its load step until rsp_ready frees the register
// synchronous reset empties the stack and sets capacity to DEPTH; no clearing pass

module bounded_stack_with_deep_access #(
   parameter int DEPTH     = 256,
   parameter int WORD_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [bsda_pkg::CSR_BITS-1:0]        csr_wr_data,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [2:0]                           req_operation,
   input  logic signed [bsda_pkg::IN_BITS-1:0]  req_value,
   input  logic [bsda_pkg::IDX_BITS-1:0]        req_depth_index,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [bsda_pkg::OUT_BITS-1:0] rsp_data,
   output logic [1:0]                           rsp_status,
   output logic [bsda_pkg::FILL_OUT-1:0]        rsp_fill_count,
   output logic                                 rsp_is_empty,
   output logic                                 rsp_is_full
);
   import bsda_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   bsda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   bsda_dp #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_operation   (req_operation),
      .req_value       (req_value),
      .req_depth_index (req_depth_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .rsp_status      (rsp_status),
      .rsp_fill_count  (rsp_fill_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full)
   );

endmodule

`default_nettype wire

// ----- tb/bounded_stack_with_deep_access_tb.sv -----
`timescale 1ns / 1ps

module bounded_stack_with_deep_access_tb;
   import bsda_pkg::*;

   localparam int STACK_DEPTH = 256;
   localparam int SETTLE_CYCLES = 6;
   localparam int LONG_HOLD = 300;
   localparam int STALL_LIMIT = 2000;
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [31:0] data;
      status_type  status;
      logic [8:0]  fill;
      logic        empty;
      logic        full;
   } stack_result_type;

   class stack_mirror_type;
      logic [31:0]      words [STACK_DEPTH];
      int unsigned      fill;
      logic [8:0]       capacity;
      stack_result_type pending_results [$];
      int unsigned      mismatches;

      function new();
         fill = 0;
         capacity = 9'(STACK_DEPTH);
         mismatches = 0;
      endfunction

      function void set_capacity(logic [8:0] v);
         capacity = v;
      endfunction

      function int unsigned outstanding();
         return pending_results.size();
      endfunction

      // work out the result of one accepted request and update the stack copy
      function void note_request(logic [2:0] op, logic [31:0] val, logic [7:0] idx);
         stack_result_type r;
         int unsigned      lim;
         lim = (capacity > STACK_DEPTH) ? STACK_DEPTH : capacity;
         r.data = '0;
         r.status = ST_OK;
         case (op) inside
            OP_PUSH: begin
               if (fill >= lim) begin
                  r.status = ST_FULL;
                  r.data = '1;
               end else begin
                  words[fill] = val;
                  fill++;
               end
            end
            OP_POP, OP_READ_TOP: begin
               if (fill == 0) begin
                  r.status = ST_EMPTY;
                  r.data = '1;
               end else begin
                  r.data = words[fill - 1];
                  if (op == OP_POP) fill--;
               end
            end
            OP_READ_DEEP, OP_WRITE_DEEP: begin
               if (fill == 0) begin
                  r.status = ST_EMPTY;
                  r.data = '1;
               end else if (idx >= fill) begin
                  r.status = ST_RANGE;
                  r.data = '1;
               end else if (op == OP_READ_DEEP) begin
                  r.data = words[fill - 1 - idx];
               end else begin
                  words[fill - 1 - idx] = val;
               end
            end
            OP_CLEAR: fill = 0;
            default: ;
         endcase
         r.fill = 9'(fill);
         r.empty = (fill == 0);
         r.full = (fill >= lim);
         pending_results.push_back(r);
      endfunction

      function void check_result(logic [31:0] data, logic [1:0] status, logic [8:0] fill_count,
                                 logic is_empty, logic is_full);
         stack_result_type e;
         if (pending_results.size() == 0) begin
            $error("unexpected result transfer: data %0d status %0d", $signed(data), status);
            mismatches++;
            return;
         end
         e = pending_results.pop_front();
         if (data !== e.data) begin
            $error("data mismatch: expected %0d, actual %0d", $signed(e.data), $signed(data));
            mismatches++;
         end
         if (status !== e.status) begin
            $error("status mismatch: expected %0d, actual %0d", e.status, status);
            mismatches++;
         end
         if (fill_count !== e.fill) begin
            $error("fill_count mismatch: expected %0d, actual %0d", e.fill, fill_count);
            mismatches++;
         end
         if (is_empty !== e.empty) begin
            $error("is_empty mismatch: expected %0d, actual %0d", e.empty, is_empty);
            mismatches++;
         end
         if (is_full !== e.full) begin
            $error("is_full mismatch: expected %0d, actual %0d", e.full, is_full);
            mismatches++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_wr_en;
   logic [CSR_BITS-1:0] csr_wr_data;
   logic               req_valid;
   logic               req_ready;
   logic [2:0]         req_operation;
   logic signed [IN_BITS-1:0] req_value;
   logic [IDX_BITS-1:0] req_depth_index;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [OUT_BITS-1:0] rsp_data;
   logic [1:0]         rsp_status;
   logic [FILL_OUT-1:0] rsp_fill_count;
   logic               rsp_is_empty;
   logic               rsp_is_full;

   stack_mirror_type mirror = new();
   bit          calm = 1'b0;
   bit          long_hold_req = 1'b0;
   int unsigned quiet_cycles;

   bounded_stack_with_deep_access #(
      .DEPTH(STACK_DEPTH),
      .WORD_BITS(32)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_operation(req_operation),
      .req_value(req_value),
      .req_depth_index(req_depth_index),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .rsp_status(rsp_status),
      .rsp_fill_count(rsp_fill_count),
      .rsp_is_empty(rsp_is_empty),
      .rsp_is_full(rsp_is_full)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // result side: random stalls, plus one long hold-off when asked
   initial begin : rsp_side
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         mirror.check_result(rsp_data, rsp_status, rsp_fill_count, rsp_is_empty, rsp_is_full);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // offer one request and hold it until the transfer happens
   task automatic send_request(input logic [2:0] op, input logic [31:0] val,
                               input logic [7:0] idx);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_value <= val;
      req_depth_index <= idx;
      do @(posedge clock); while (!req_ready);
      mirror.note_request(op, val, idx);
   endtask

   // wait until every result is back and the pipeline has gone quiet
   task automatic drain();
      req_valid <= 1'b0;
      while (mirror.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [8:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      mirror.set_capacity(v);
   endtask

   initial begin : stimulus
      int unsigned caps [8];
      int unsigned push_pct [8];
      int unsigned clear_pct [8];
      int unsigned counts [8];
      int unsigned r;
      logic [2:0]  op;
      logic [7:0]  idx;

      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      req_valid <= 1'b0;
      req_operation <= OP_PUSH;
      req_value <= '0;
      req_depth_index <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty-stack failures
      send_request(OP_POP, 32'h0, 8'd0);
      send_request(OP_READ_TOP, 32'h0, 8'd0);
      send_request(OP_READ_DEEP, 32'h0, 8'd0);
      send_request(OP_WRITE_DEEP, 32'h5, 8'd0);
      // word extremes
      send_request(OP_PUSH, 32'h7FFF_FFFF, 8'd0);
      send_request(OP_PUSH, 32'h8000_0000, 8'd0);
      send_request(OP_PUSH, 32'hFFFF_FFFF, 8'd0);
      send_request(OP_PUSH, 32'h0, 8'd0);
      send_request(OP_READ_TOP, 32'h0, 8'd0);
      send_request(OP_READ_DEEP, 32'h0, 8'd0);
      send_request(OP_READ_DEEP, 32'h0, 8'd3);
      // index at and past the fill, and an in-range deep write read back
      send_request(OP_READ_DEEP, 32'h0, 8'd4);
      send_request(OP_READ_DEEP, 32'h0, 8'd255);
      send_request(OP_WRITE_DEEP, 32'h1234_5678, 8'd2);
      send_request(OP_READ_DEEP, 32'h0, 8'd2);
      send_request(OP_WRITE_DEEP, 32'hDEAD_BEEF, 8'd4);
      // unused operation codes leave the stack alone
      send_request(OP_SPARE_6, 32'hFFFF_FFFF, 8'hFF);
      send_request(OP_SPARE_7, 32'h0, 8'd0);
      send_request(OP_POP, 32'h0, 8'd0);
      send_request(OP_POP, 32'h0, 8'd0);
      // capacity at the fill: push dropped
      drain();
      write_capacity(9'd2);
      send_request(OP_PUSH, 32'h55AA_55AA, 8'd0);
      send_request(OP_POP, 32'h0, 8'd0);
      // zero capacity counts as full
      drain();
      write_capacity(9'd0);
      send_request(OP_PUSH, 32'h1, 8'd0);
      send_request(OP_CLEAR, 32'h0, 8'd0);

      caps = '{256, 1, 0, 511, 5, 300, 17, 256};
      push_pct = '{90, 50, 40, 60, 50, 55, 50, 50};
      clear_pct = '{0, 2, 3, 1, 2, 1, 2, 1};
      counts = '{320, 150, 100, 200, 150, 200, 130, 150};

      for (int p = 0; p < 8; p++) begin
         drain();
         calm = (p == 7) || (p == 4);
         write_capacity(9'(caps[p]));
         for (int n = 0; n < counts[p]; n++) begin
            // hold the result side off while requests keep coming
            if (p == 0 && n == 40) long_hold_req = 1'b1;
            r = $urandom_range(0, 99);
            if (r < push_pct[p]) begin
               op = OP_PUSH;
            end else if (r < push_pct[p] + clear_pct[p]) begin
               op = OP_CLEAR;
            end else if (r == 99) begin
               op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
            end else begin
               case ($urandom_range(0, 3))
                  0: op = OP_POP;
                  1: op = OP_READ_TOP;
                  2: op = OP_READ_DEEP;
                  default: op = OP_WRITE_DEEP;
               endcase
            end
            // mostly in-range depths, some anywhere
            if ($urandom_range(0, 9) == 0 || mirror.fill == 0)
               idx = 8'($urandom);
            else
               idx = 8'($urandom_range(0, mirror.fill - 1));
            send_request(op, $urandom, idx);
         end
      end

      drain();
      if (mirror.mismatches == 0 && mirror.outstanding() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
